@@ sv/cfp_pkg.sv @@
// shared types, constants and the arctangent table for the camera frame to polar block
package cfp_pkg;

   // sequencing limits
   localparam int CORDIC_TABLE_SIZE = 20;
   localparam int SQRT_STEPS = 9;

   // angle constants, degrees in q16
   localparam logic [22:0] ANGLE_QUARTER = 23'd5898240;
   localparam logic [23:0] ANGLE_HALF = 24'd11796480;
   localparam logic [24:0] ROUND_HALF = 25'd32768;

   // compass conversion
   localparam logic [9:0] COMPASS_OFFSET = 10'd450;
   localparam logic [9:0] FULL_TURN = 10'd360;

   // register indexes
   localparam logic [1:0] CSR_MARKER_BYTE = 2'd0;
   localparam logic [1:0] CSR_CENTRE_X = 2'd1;
   localparam logic [1:0] CSR_CENTRE_Y = 2'd2;

   typedef enum logic [1:0] {
      PHASE_HUNT,
      PHASE_ONE,
      PHASE_COLLECT
   } sync_phase_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_BLUE_START,
      T_BLUE_WAIT,
      T_YELLOW_START,
      T_YELLOW_WAIT,
      T_HOLD
   } top_state_type;

   typedef enum logic [1:0] {
      P_IDLE,
      P_ITER,
      P_CLAMP,
      P_ANGLE
   } polar_state_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic       blue_seen;
      logic [8:0] blue_angle;
      logic [8:0] blue_distance;
      logic       yellow_seen;
      logic [8:0] yellow_angle;
      logic [8:0] yellow_distance;
   } rsp_payload_type;

   typedef struct packed {
      logic              start;
      logic signed [8:0] dx;
      logic signed [8:0] dy;
   } polar_req_type;

   typedef struct packed {
      logic       done;
      logic [8:0] angle;
      logic [8:0] distance;
   } polar_status_type;

   // arctangent of 2^-i in degrees, q16, rounded to nearest
   function automatic logic [21:0] atan_q16(input logic [4:0] idx);
      logic [21:0] val;
      unique case (idx)
         5'd0: val = 22'd2949120;
         5'd1: val = 22'd1740967;
         5'd2: val = 22'd919879;
         5'd3: val = 22'd466945;
         5'd4: val = 22'd234379;
         5'd5: val = 22'd117304;
         5'd6: val = 22'd58666;
         5'd7: val = 22'd29335;
         5'd8: val = 22'd14668;
         5'd9: val = 22'd7334;
         5'd10: val = 22'd3667;
         5'd11: val = 22'd1833;
         5'd12: val = 22'd917;
         5'd13: val = 22'd458;
         5'd14: val = 22'd229;
         5'd15: val = 22'd115;
         5'd16: val = 22'd57;
         5'd17: val = 22'd29;
         5'd18: val = 22'd14;
         5'd19: val = 22'd7;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

@@ sv/cfp_stream_if.sv @@
// valid/ready stream interface carrying one payload word
interface cfp_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/cfp_polar.sv @@
// iterative cordic and square root unit giving compass angle and distance of one offset
module cfp_polar import cfp_pkg::*; #(
   parameter int CORDIC_STEPS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  polar_req_type    req,
   output polar_status_type status
);

   localparam int STEPS = (CORDIC_STEPS < CORDIC_TABLE_SIZE) ? CORDIC_STEPS : CORDIC_TABLE_SIZE;
   localparam int ITERS = (STEPS > SQRT_STEPS) ? STEPS : SQRT_STEPS;
   localparam logic [4:0] LAST_ITER = 5'(ITERS - 1);
   localparam logic [4:0] STEP_LIMIT = 5'(STEPS);

   polar_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [7:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic        dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in;
   logic signed [19:0] x_ff, x_in, y_ff, y_in;
   logic signed [24:0] z_ff, z_in;
   logic [16:0] rem_ff, rem_in;
   logic [17:0] root_ff, root_in;
   logic [16:0] bit_ff, bit_in;
   logic [23:0] mag_ff, mag_in;
   logic [8:0]  dist_ff, dist_in;

   logic do_load, do_iter, do_clamp;

   // load stage
   logic [8:0]  dx_mag, dy_mag;
   logic [15:0] ax_sq, ay_sq;
   logic [16:0] n_new;

   // shared step datapath
   logic signed [19:0] xs, ys;
   logic signed [24:0] atan_step;
   logic [17:0] trial;
   logic        fits;

   // finishing
   logic [22:0] first_quad;
   logic [24:0] round_sum;
   logic [8:0]  rmag;
   logic [9:0]  raw_angle;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         P_IDLE:  if (req.start) state_in = P_ITER;
         P_ITER:  if (cnt_ff == LAST_ITER) state_in = P_CLAMP;
         P_CLAMP: state_in = P_ANGLE;
         P_ANGLE: state_in = P_IDLE;
         default: state_in = P_IDLE;
      endcase
   end

   always_comb begin
      do_load = (state_ff == P_IDLE) && req.start;
      do_iter = (state_ff == P_ITER);
      do_clamp = (state_ff == P_CLAMP);
   end

   always_comb begin
      dx_mag = req.dx[8] ? 9'(-req.dx) : req.dx;
      dy_mag = req.dy[8] ? 9'(-req.dy) : req.dy;
      ax_sq = {8'd0, dx_mag[7:0]} * {8'd0, dx_mag[7:0]};
      ay_sq = {8'd0, dy_mag[7:0]} * {8'd0, dy_mag[7:0]};
      n_new = {1'b0, ax_sq} + {1'b0, ay_sq};

      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      atan_step = $signed({3'b000, atan_q16(cnt_ff)});
      trial = root_ff + {1'b0, bit_ff};
      fits = {1'b0, rem_ff} >= trial;

      // axes are exact, otherwise clamp the accumulated angle to the first quadrant
      if (ay_ff == 8'd0) begin
         first_quad = '0;
      end else if (ax_ff == 8'd0) begin
         first_quad = ANGLE_QUARTER;
      end else if (z_ff[24]) begin
         first_quad = '0;
      end else if (z_ff > $signed({2'b00, ANGLE_QUARTER})) begin
         first_quad = ANGLE_QUARTER;
      end else begin
         first_quad = z_ff[22:0];
      end

      round_sum = {1'b0, mag_ff} + ROUND_HALF;
      rmag = round_sum[24:16];
      raw_angle = dy_neg_ff ? COMPASS_OFFSET + {1'b0, rmag} : COMPASS_OFFSET - {1'b0, rmag};
   end

   always_comb begin
      cnt_in = cnt_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      dx_neg_in = dx_neg_ff;
      dy_neg_in = dy_neg_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      mag_in = mag_ff;
      dist_in = dist_ff;
      if (do_load) begin
         cnt_in = '0;
         ax_in = dx_mag[7:0];
         ay_in = dy_mag[7:0];
         dx_neg_in = req.dx[8];
         dy_neg_in = req.dy[8];
         x_in = $signed({4'b0000, dx_mag[7:0], 8'h00});
         y_in = $signed({4'b0000, dy_mag[7:0], 8'h00});
         z_in = '0;
         rem_in = n_new;
         root_in = '0;
         bit_in = 17'h10000;
      end else if (do_iter) begin
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff < STEP_LIMIT) begin
            if (!y_ff[19]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_step;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_step;
            end
         end
         // one result bit of the square root per cycle
         if (bit_ff != 17'd0) begin
            if (fits) begin
               rem_in = 17'({1'b0, rem_ff} - trial);
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
      end else if (do_clamp) begin
         mag_in = dx_neg_ff ? ANGLE_HALF - {1'b0, first_quad} : {1'b0, first_quad};
         dist_in = root_ff[8:0] + {8'd0, ({1'b0, rem_ff} > root_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      dx_neg_ff <= dx_neg_in;
      dy_neg_ff <= dy_neg_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      mag_ff <= mag_in;
      dist_ff <= dist_in;
   end

   assign status.done = (state_ff == P_ANGLE);
   assign status.angle = (raw_angle >= FULL_TURN) ? 9'(raw_angle - FULL_TURN) : raw_angle[8:0];
   assign status.distance = dist_ff;

endmodule

@@ sv/camera_frame_to_polar.sv @@
// top level: frame sync on camera link words and polar conversion of two targets
// a word that does not end a frame is taken and gives no result
// the last word of a frame gives one result, computed by
//   the shared cordic/square root unit running blue then yellow, one step a cycle
// req ready is low from the last word of a frame until its result sits in the output register
// synchronous active high reset: hunting for the first marker, registers at 11, 128, 128
module camera_frame_to_polar import cfp_pkg::*; #(
   parameter int FRAME_LENGTH = 10,
   parameter int CORDIC_STEPS = 12
) (
   input  logic        clock,
   input  logic        reset,
   cfp_stream_if.sink   req_stream,
   cfp_stream_if.source rsp_stream,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam logic [4:0] LAST_POS = 5'(FRAME_LENGTH - 1);

   // configuration registers
   logic [7:0] marker_ff, marker_in;
   logic [7:0] centre_x_ff, centre_x_in;
   logic [7:0] centre_y_ff, centre_y_in;

   // frame sync and collection
   sync_phase_type phase_ff, phase_in;
   logic [4:0] pos_ff, pos_in;
   logic [7:0] fields_ff [6];
   logic [7:0] fields_in [6];
   logic       accept;
   logic       frame_end;
   logic [7:0] rx;

   // sequencer
   top_state_type state_ff, state_in;
   logic          use_yellow;
   logic          out_free;
   logic          load_out;

   // per target results held until the output register is free
   logic [8:0] blue_angle_ff, blue_angle_in, blue_dist_ff, blue_dist_in;
   logic [8:0] yellow_angle_ff, yellow_angle_in, yellow_dist_ff, yellow_dist_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // offsets from the centre
   logic signed [8:0] blue_dx, blue_dy, yellow_dx, yellow_dy;

   polar_req_type    polar_req;
   polar_status_type polar_status;

   cfp_polar #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_polar (
      .clock(clock),
      .reset(reset),
      .req(polar_req),
      .status(polar_status)
   );

   assign rx = req_stream.payload.rx_byte;
   assign accept = req_stream.valid && req_stream.ready;

   // config writes, index beyond the list is dropped
   always_comb begin
      marker_in = marker_ff;
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MARKER_BYTE: marker_in = csr_data;
            CSR_CENTRE_X:    centre_x_in = csr_data;
            CSR_CENTRE_Y:    centre_y_in = csr_data;
            default: ;
         endcase
      end
   end

   // marker hunt, then byte 0 is the second marker and bytes 1 to 6 are kept
   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      fields_in = fields_ff;
      frame_end = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PHASE_HUNT: begin
               if (rx == marker_ff) phase_in = PHASE_ONE;
            end
            PHASE_ONE: begin
               if (rx == marker_ff) begin
                  phase_in = PHASE_COLLECT;
                  pos_in = '0;
               end else begin
                  phase_in = PHASE_HUNT;
               end
            end
            PHASE_COLLECT: begin
               pos_in = pos_ff + 5'd1;
               if (pos_in >= 5'd1 && pos_in <= 5'd6) begin
                  fields_in[3'(pos_in - 5'd1)] = rx;
               end
               if (pos_in == LAST_POS) begin
                  frame_end = 1'b1;
                  phase_in = PHASE_HUNT;
                  pos_in = '0;
               end
            end
            default: phase_in = PHASE_HUNT;
         endcase
      end
   end

   assign blue_dx = $signed({1'b0, fields_ff[1]}) - $signed({1'b0, centre_x_ff});
   assign blue_dy = $signed({1'b0, fields_ff[2]}) - $signed({1'b0, centre_y_ff});
   assign yellow_dx = $signed({1'b0, fields_ff[4]}) - $signed({1'b0, centre_x_ff});
   assign yellow_dy = $signed({1'b0, fields_ff[5]}) - $signed({1'b0, centre_y_ff});

   assign out_free = !rsp_valid_ff || rsp_stream.ready;

   // next state: blue, then yellow through the shared unit, then hand off
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:         if (frame_end) state_in = T_BLUE_START;
         T_BLUE_START:   state_in = T_BLUE_WAIT;
         T_BLUE_WAIT:    if (polar_status.done) state_in = T_YELLOW_START;
         T_YELLOW_START: state_in = T_YELLOW_WAIT;
         T_YELLOW_WAIT:  if (polar_status.done) state_in = T_HOLD;
         T_HOLD:         if (out_free) state_in = T_IDLE;
         default:        state_in = T_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stream.ready = (state_ff == T_IDLE);
      use_yellow = (state_ff == T_YELLOW_START) || (state_ff == T_YELLOW_WAIT);
      polar_req.start = (state_ff == T_BLUE_START) || (state_ff == T_YELLOW_START);
      polar_req.dx = use_yellow ? yellow_dx : blue_dx;
      polar_req.dy = use_yellow ? yellow_dy : blue_dy;
      load_out = (state_ff == T_HOLD) && out_free;
   end

   // result capture and output word
   always_comb begin
      blue_angle_in = blue_angle_ff;
      blue_dist_in = blue_dist_ff;
      yellow_angle_in = yellow_angle_ff;
      yellow_dist_in = yellow_dist_ff;
      if (polar_status.done && state_ff == T_BLUE_WAIT) begin
         blue_angle_in = polar_status.angle;
         blue_dist_in = polar_status.distance;
      end
      if (polar_status.done && state_ff == T_YELLOW_WAIT) begin
         yellow_angle_in = polar_status.angle;
         yellow_dist_in = polar_status.distance;
      end

      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_stream.ready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.blue_seen = (fields_ff[0] != 8'd0);
         rsp_payload_in.blue_angle = blue_angle_ff;
         rsp_payload_in.blue_distance = blue_dist_ff;
         rsp_payload_in.yellow_seen = (fields_ff[3] != 8'd0);
         rsp_payload_in.yellow_angle = yellow_angle_ff;
         rsp_payload_in.yellow_distance = yellow_dist_ff;
      end
   end

   assign rsp_stream.valid = rsp_valid_ff;
   assign rsp_stream.payload = rsp_payload_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= 8'd11;
         centre_x_ff <= 8'd128;
         centre_y_ff <= 8'd128;
         phase_ff <= PHASE_HUNT;
         pos_ff <= '0;
         state_ff <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         marker_ff <= marker_in;
         centre_x_ff <= centre_x_in;
         centre_y_ff <= centre_y_in;
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      fields_ff <= fields_in;
      blue_angle_ff <= blue_angle_in;
      blue_dist_ff <= blue_dist_in;
      yellow_angle_ff <= yellow_angle_in;
      yellow_dist_ff <= yellow_dist_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

@@ tb/sv/camera_frame_to_polar_tb.sv @@
// self-checking testbench for the camera frame to polar block
module camera_frame_to_polar_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfp_pkg::*;

   // block configuration under test, matches the rtl defaults
   localparam int FRAME_BYTES = 10;
   localparam int CORDIC_ITERATIONS = 12;

   // drain time covers the result latency, padded for the quiet pauses
   localparam int DRAIN_CYCLES = 2 * CORDIC_ITERATIONS + 7 + 12;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_WORDS = 90;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int Q16_ONE = 65536;

   // golden model of the frame sync and polar conversion, plus the result checker
   class target_polar_tracker;
      rsp_payload_type expected_polar[$];
      int unsigned     mismatches;
      logic [7:0]      marker_byte;
      logic [7:0]      centre_x;
      logic [7:0]      centre_y;
      sync_phase_type  phase;
      int unsigned     position;
      logic [7:0]      fields[6];
      int              frame_length;
      int              steps;

      function new(int frame_length_in, int steps_in);
         frame_length = frame_length_in;
         steps = steps_in;
         mismatches = 0;
         marker_byte = 8'd11;
         centre_x = 8'd128;
         centre_y = 8'd128;
         phase = PHASE_HUNT;
         position = 0;
         foreach (fields[i]) fields[i] = 8'd0;
      endfunction

      function void write_register(logic [1:0] index, logic [7:0] value);
         case (index)
            CSR_MARKER_BYTE: marker_byte = value;
            CSR_CENTRE_X: centre_x = value;
            CSR_CENTRE_Y: centre_y = value;
            default: ;
         endcase
      endfunction

      // arctangent of 2^-i in q16 degrees
      function int arctan_q16(int i);
         int v;
         case (i)
            0: v = 2949120;
            1: v = 1740967;
            2: v = 919879;
            3: v = 466945;
            4: v = 234379;
            5: v = 117304;
            6: v = 58666;
            7: v = 29335;
            8: v = 14668;
            9: v = 7334;
            10: v = 3667;
            11: v = 1833;
            12: v = 917;
            13: v = 458;
            14: v = 229;
            15: v = 115;
            16: v = 57;
            17: v = 29;
            18: v = 14;
            19: v = 7;
            default: v = 0;
         endcase
         return v;
      endfunction

      function void to_polar(int dx, int dy, output logic [8:0] angle,
                             output logic [8:0] distance);
         int ax, ay, a, s, mag, r, c, x, y, z, xs, ys, n, root;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         if (ay == 0) begin
            a = 0;
         end else if (ax == 0) begin
            a = 90 * Q16_ONE;
         end else begin
            x = ax * 256;
            y = ay * 256;
            z = 0;
            for (int i = 0; i < steps && i < 20; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + arctan_q16(i);
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - arctan_q16(i);
               end
            end
            if (z < 0) z = 0;
            if (z > 90 * Q16_ONE) z = 90 * Q16_ONE;
            a = z;
         end
         if (dx >= 0) s = (dy >= 0) ? a : -a;
         else s = (dy >= 0) ? (180 * Q16_ONE - a) : -(180 * Q16_ONE - a);
         mag = (s < 0) ? -s : s;
         r = (mag + Q16_ONE / 2) / Q16_ONE;
         if (s < 0) r = -r;
         c = 450 - r;
         if (c >= 360) c = c - 360;
         n = ax * ax + ay * ay;
         root = 0;
         while ((root + 1) * (root + 1) <= n) root++;
         if (n - root * root > root) root++;
         angle = c[8:0];
         distance = root[8:0];
      endfunction

      // one accepted link word
      function void note_word(logic [7:0] b);
         rsp_payload_type fix;
         case (phase)
            PHASE_HUNT: begin
               if (b == marker_byte) phase = PHASE_ONE;
            end
            PHASE_ONE: begin
               if (b == marker_byte) begin
                  phase = PHASE_COLLECT;
                  position = 0;
               end else begin
                  phase = PHASE_HUNT;
               end
            end
            default: begin
               position = (position + 1) % 32;
               if (position >= 1 && position <= 6) fields[position - 1] = b;
               if (position + 1 >= frame_length) begin
                  phase = PHASE_HUNT;
                  position = 0;
                  fix.blue_seen = (fields[0] != 8'd0);
                  to_polar(int'(fields[1]) - int'(centre_x), int'(fields[2]) - int'(centre_y),
                           fix.blue_angle, fix.blue_distance);
                  fix.yellow_seen = (fields[3] != 8'd0);
                  to_polar(int'(fields[4]) - int'(centre_x), int'(fields[5]) - int'(centre_y),
                           fix.yellow_angle, fix.yellow_distance);
                  expected_polar.push_back(fix);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      // one accepted result word
      function void check_word(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_polar.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, got %h", $time, got);
            return;
         end
         want = expected_polar.pop_front();
         compare_field("blue_seen", want.blue_seen, got.blue_seen);
         compare_field("blue_angle", want.blue_angle, got.blue_angle);
         compare_field("blue_distance", want.blue_distance, got.blue_distance);
         compare_field("yellow_seen", want.yellow_seen, got.yellow_seen);
         compare_field("yellow_angle", want.yellow_angle, got.yellow_angle);
         compare_field("yellow_distance", want.yellow_distance, got.yellow_distance);
      endfunction

      function int pending();
         return expected_polar.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   cfp_stream_if #(.payload_type(req_payload_type)) req_stream ();
   cfp_stream_if #(.payload_type(rsp_payload_type)) rsp_stream ();

   camera_frame_to_polar #(
      .FRAME_LENGTH(FRAME_BYTES),
      .CORDIC_STEPS(CORDIC_ITERATIONS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_stream(req_stream),
      .rsp_stream(rsp_stream),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   target_polar_tracker tracker;

   // link words still to be sent in the current phase
   logic [7:0] link_words[$];

   // idling knobs: sender gap and receiver stall odds in percent
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // long receiver hold-off requests, served by the receiver process
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;

   int quiet_cycles = 0;

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: check every accepted result word, then pick ready for the next edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_stream.ready <= 1'b0;
      end else begin
         if (rsp_stream.valid && rsp_stream.ready) tracker.check_word(rsp_stream.payload);
         if (hold_left > 0) begin
            // long hold-off so the block fills up and stalls its input
            hold_left <= hold_left - 1;
            rsp_stream.ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            rsp_stream.ready <= 1'b0;
         end else begin
            rsp_stream.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog: too many cycles without any word moving on either channel
   always @(posedge clock) begin
      if ((req_stream.valid && req_stream.ready) || (rsp_stream.valid && rsp_stream.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // offer one link word, with a random gap before it, and wait until it is taken
   task automatic push_word(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_stream.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_stream.valid <= 1'b1;
      req_stream.payload <= b;
      do @(posedge clock); while (!req_stream.ready);
      tracker.note_word(b);
   endtask

   // all three registers, one write per cycle, write enable dropped after the last
   task automatic load_registers(input logic [7:0] marker, input logic [7:0] cx,
                                 input logic [7:0] cy);
      csr_write <= 1'b1;
      csr_index <= CSR_MARKER_BYTE;
      csr_data <= marker;
      @(posedge clock);
      csr_index <= CSR_CENTRE_X;
      csr_data <= cx;
      @(posedge clock);
      csr_index <= CSR_CENTRE_Y;
      csr_data <= cy;
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.write_register(CSR_MARKER_BYTE, marker);
      tracker.write_register(CSR_CENTRE_X, cx);
      tracker.write_register(CSR_CENTRE_Y, cy);
   endtask

   // wait for every result, then let a frame end still in flight settle
   task automatic wait_for_quiet();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // target coordinate: centre, edges, near centre or anywhere
   function automatic logic [7:0] pick_coord(input logic [7:0] centre);
      logic [7:0] v;
      case ($urandom_range(7))
         0: v = centre;
         1: v = 8'd0;
         2: v = 8'hFF;
         3: v = centre + 8'($urandom_range(6)) - 8'd3;
         default: v = 8'($urandom_range(255));
      endcase
      return v;
   endfunction

   function automatic logic [7:0] pick_seen();
      return ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
   endfunction

   // mostly well-formed frames, some lone markers and line noise
   function automatic void queue_sequence();
      int pick;
      int noise;
      logic [7:0] m;
      pick = $urandom_range(99);
      m = tracker.marker_byte;
      if (pick < 8) begin
         // lone marker: the next word breaks the pair
         link_words.push_back(m);
         link_words.push_back(m ^ 8'($urandom_range(1, 255)));
      end else if (pick < 15) begin
         noise = $urandom_range(1, 3);
         repeat (noise) link_words.push_back(8'($urandom_range(255)));
      end else begin
         link_words.push_back(m);
         link_words.push_back(m);
         link_words.push_back(pick_seen());
         link_words.push_back(pick_coord(tracker.centre_x));
         link_words.push_back(pick_coord(tracker.centre_y));
         link_words.push_back(pick_seen());
         link_words.push_back(pick_coord(tracker.centre_x));
         link_words.push_back(pick_coord(tracker.centre_y));
         for (int i = 7; i < FRAME_BYTES; i++) link_words.push_back(8'($urandom_range(255)));
      end
   endfunction

   initial begin
      logic [7:0] marker;
      logic [7:0] cx;
      logic [7:0] cy;

      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= CSR_MARKER_BYTE;
      csr_data <= 8'd0;
      req_stream.valid <= 1'b0;
      req_stream.payload <= '0;
      tracker = new(FRAME_BYTES, CORDIC_ITERATIONS);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset settings (marker 11, centre 128,128):
      // lone marker, then blue at the centre with yellow on the negative x axis,
      // then blue at the far corner with yellow on the negative y axis
      link_words = '{8'd11, 8'd5,
                     8'd11, 8'd11, 8'd0, 8'd128, 8'd128, 8'd255, 8'd0, 8'd128,
                     8'd0, 8'd255, 8'd170,
                     8'd11, 8'd11, 8'd1, 8'd255, 8'd255, 8'd128, 8'd128, 8'd0,
                     8'd85, 8'd11, 8'd0};
      while (link_words.size() != 0) push_word(link_words.pop_front());
      req_stream.valid <= 1'b0;

      // random phases, each with its own register setting and idling mix;
      // a phase may stop mid-frame so new settings also land inside a frame
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_for_quiet();
         marker = 8'($urandom_range(255));
         cx = 8'($urandom_range(255));
         cy = 8'($urandom_range(255));
         case (p)
            0: begin
               marker = 8'd0;
               cx = 8'd0;
               cy = 8'd0;
            end
            1: begin
               marker = 8'hFF;
               cx = 8'hFF;
               cy = 8'hFF;
            end
            3: begin
               marker = 8'hA5;
               cx = 8'd0;
               cy = 8'hFF;
            end
            4: begin
               cx = 8'hFF;
               cy = 8'd0;
            end
            7: begin
               marker = 8'd11;
               cx = 8'd128;
               cy = 8'd128;
            end
            default: ;
         endcase
         load_registers(marker, cx, cy);

         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 81;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 81;
            end
            default: begin
               send_idle_pct = 18;
               rsp_stall_pct <= 18;
            end
         endcase
         // back pressure: receiver holds off while words keep coming at full rate
         if (p == 4) holds_asked <= holds_asked + 1;

         repeat (PHASE_WORDS) begin
            if (link_words.size() == 0) queue_sequence();
            push_word(link_words.pop_front());
         end
         req_stream.valid <= 1'b0;
      end

      // drain with the receiver always ready, then give late extras a chance to show
      rsp_stall_pct <= 0;
      wait_for_quiet();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/cfp_pkg.sv
sv/cfp_stream_if.sv
sv/cfp_polar.sv
sv/camera_frame_to_polar.sv
tb/sv/camera_frame_to_polar_tb.sv
